// File: rtl/core/cet_pkg.sv
// cet_pkg: shared constants and types for the circle exit time core
// no dependencies; imported by every module of the core

package cet_pkg;

    localparam int POS_WIDTH_DEF   = 20;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int RADIUS_W = 19;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 19'd256000;
    localparam int SPEED_W  = 12;
    localparam int TIME_W   = 32;
    localparam int TURN_W   = 24;
    localparam int QUARTER_W = 22;
    localparam int ROOT_W   = 19;
    localparam int DISC_W   = 2 * ROOT_W;
    localparam int SINE_W   = 31;
    localparam int KMIN_W   = 22;

    localparam logic [QUARTER_W:0] QUARTER_STEPS = 23'h400000;

    // sine polynomial, q30, odd powers nine down to one
    localparam logic signed [32:0] SIN_C9 = 33'sd172272;
    localparam logic signed [32:0] SIN_C7 = -33'sd5026995;
    localparam logic signed [32:0] SIN_C5 = 33'sd85569306;
    localparam logic signed [32:0] SIN_C3 = -33'sd693598668;
    localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;

    localparam logic [SINE_W-1:0] Q30_ONE = 31'h40000000;
    localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;

    // 60 / 1.15077954 in q16
    localparam logic [KMIN_W-1:0] MIN_PER_NM_Q16 = 22'd3416953;

    localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFFFFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]           quad;
        logic [QUARTER_W:0]   r;
        logic [QUARTER_W:0]   rc;
        logic [SPEED_W-1:0]   speed;
        logic                 zero;
    } cls_t;

endpackage

// File: rtl/core/cet_queue.sv
// cet_queue: two-entry queue between the front and back parts
// uses cet_pkg only for the house import

module cet_queue
    import cet_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/core/cet_front.sv
// cet_front: classifies an incoming transaction (quadrant, offsets, zero speed)
// depends on cet_pkg

module cet_front
    import cet_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic [ANGLE_WIDTH-1:0] heading,
    input  logic [SPEED_W-1:0]     speed_knots,
    output cls_t                   cls
);

    logic [TURN_W-1:0] turn;

    // heading widened to a 24-bit turn fraction
    assign turn = TURN_W'(heading) << (TURN_W - ANGLE_WIDTH);

    always_comb
    begin
        cls.quad  = turn[TURN_W-1 -: 2];
        cls.r     = {1'b0, turn[QUARTER_W-1:0]};
        cls.rc    = QUARTER_STEPS - {1'b0, turn[QUARTER_W-1:0]};
        cls.speed = speed_knots;
        cls.zero  = (speed_knots == '0);
    end

endmodule

// File: rtl/core/cet_sine.sv
// cet_sine: six-stage quarter-wave sine, q30 odd polynomial by horner
// depends on cet_pkg

module cet_sine
    import cet_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [QUARTER_W:0]  r,
    output logic [SINE_W-1:0]   sine
);

    logic signed [31:0] u_in;
    logic signed [63:0] sq;
    logic signed [31:0] u_reg [1:5];
    logic signed [31:0] u2_reg [1:4];
    logic signed [32:0] p_reg [2:5];
    logic signed [64:0] m2, m3, m4, m5, m6;
    logic signed [32:0] f6;
    logic [SINE_W-1:0]  sine_reg;

    assign u_in = signed'({1'b0, r, 8'd0});
    assign sq   = u_in * u_in;
    assign m2   = SIN_C9 * u2_reg[1];
    assign m3   = p_reg[2] * u2_reg[2];
    assign m4   = p_reg[3] * u2_reg[3];
    assign m5   = p_reg[4] * u2_reg[4];
    assign m6   = p_reg[5] * u_reg[5];
    assign f6   = 33'(m6 >>> 30);
    assign sine = sine_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[1]  <= u_in;
            u2_reg[1] <= 32'(sq >>> 30);
            for (int k = 2; k <= 5; k++)
            begin
                u_reg[k] <= u_reg[k-1];
            end
            for (int k = 2; k <= 4; k++)
            begin
                u2_reg[k] <= u2_reg[k-1];
            end
            p_reg[2] <= SIN_C7 + 33'(m2 >>> 30);
            p_reg[3] <= SIN_C5 + 33'(m3 >>> 30);
            p_reg[4] <= SIN_C3 + 33'(m4 >>> 30);
            p_reg[5] <= SIN_C1 + 33'(m5 >>> 30);
            // clip to the closed range zero to one
            if (f6 < 0)
            begin
                sine_reg <= '0;
            end
            else if (f6 > signed'({2'b00, Q30_ONE}))
            begin
                sine_reg <= Q30_ONE;
            end
            else
            begin
                sine_reg <= f6[SINE_W-1:0];
            end
        end
    end

endmodule

// File: rtl/core/cet_back.sv
// cet_back: projection, square root, scaling and division pipeline, result register
// depends on cet_pkg and cet_sine

module cet_back
    import cet_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [POS_WIDTH-1:0] in_x,
    input  logic signed [POS_WIDTH-1:0] in_y,
    input  cls_t                        in_cls,
    input  logic [RADIUS_W-1:0]         radius,
    output logic                        out_valid,
    output logic signed [TIME_W-1:0]    exit_minutes,
    output logic                        no_exit,
    output logic                        zero_speed
);

    localparam int PW   = POS_WIDTH;
    localparam int DW   = PW + 2;
    localparam int EW   = (PW + 3 > ROOT_W + 2) ? PW + 3 : ROOT_W + 2;
    localparam int PRW  = EW + KMIN_W;
    localparam int SLAT = 6;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // sine lanes
    logic [SINE_W-1:0] sp, cp;

    cet_sine u_sin
    (
        .clk  (clk),
        .en   (adv),
        .r    (in_cls.r),
        .sine (sp)
    );

    cet_sine u_cos
    (
        .clk  (clk),
        .en   (adv),
        .r    (in_cls.rc),
        .sine (cp)
    );

    // side data alongside the sine lanes
    logic                 s_v_reg [SLAT];
    logic signed [PW-1:0] s_x_reg [SLAT];
    logic signed [PW-1:0] s_y_reg [SLAT];
    logic [1:0]           s_q_reg [SLAT];
    logic [SPEED_W-1:0]   s_s_reg [SLAT];
    logic                 s_z_reg [SLAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLAT; k++)
            begin
                s_v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s_v_reg[0] <= in_valid;
            for (int k = 1; k < SLAT; k++)
            begin
                s_v_reg[k] <= s_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_x_reg[0] <= in_x;
            s_y_reg[0] <= in_y;
            s_q_reg[0] <= in_cls.quad;
            s_s_reg[0] <= in_cls.speed;
            s_z_reg[0] <= in_cls.zero;
            for (int k = 1; k < SLAT; k++)
            begin
                s_x_reg[k] <= s_x_reg[k-1];
                s_y_reg[k] <= s_y_reg[k-1];
                s_q_reg[k] <= s_q_reg[k-1];
                s_s_reg[k] <= s_s_reg[k-1];
                s_z_reg[k] <= s_z_reg[k-1];
            end
        end
    end

    // stage a: quadrant select and four products
    logic signed [31:0]    spv, cpv, sn, cs;
    logic signed [PW+31:0] xc_next, ys_next, xs_next, yc_next;
    logic signed [PW+31:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic                  a_v_reg, a_z_reg;
    logic [SPEED_W-1:0]    a_s_reg;

    assign spv = signed'({1'b0, sp});
    assign cpv = signed'({1'b0, cp});

    always_comb
    begin
        case (s_q_reg[SLAT-1])
            QUAD_0:
            begin
                sn = spv;
                cs = cpv;
            end
            QUAD_1:
            begin
                sn = cpv;
                cs = -spv;
            end
            QUAD_2:
            begin
                sn = -spv;
                cs = -cpv;
            end
            QUAD_3:
            begin
                sn = -cpv;
                cs = spv;
            end
            default:
            begin
                sn = spv;
                cs = cpv;
            end
        endcase
        xc_next = s_x_reg[SLAT-1] * cs;
        ys_next = s_y_reg[SLAT-1] * sn;
        xs_next = s_x_reg[SLAT-1] * sn;
        yc_next = s_y_reg[SLAT-1] * cs;
    end

    // stage b: dot and perpendicular, rounded to q.8
    logic signed [PW+33:0] dsum, psum;
    logic signed [DW-1:0]  b_dot_reg, b_perp_reg;
    logic                  b_v_reg, b_z_reg;
    logic [SPEED_W-1:0]    b_s_reg;

    assign dsum = xc_reg + ys_reg + HALF_Q30;
    assign psum = xs_reg - yc_reg + HALF_Q30;

    // stage c: perpendicular magnitude against radius
    logic [DW-1:0]        pabs;
    logic                 ne_c;
    logic signed [DW-1:0] c_dot_reg;
    logic [RADIUS_W-1:0]  c_pm_reg;
    logic                 c_v_reg, c_z_reg, c_ne_reg;
    logic [SPEED_W-1:0]   c_s_reg;

    assign pabs = (b_perp_reg < 0) ? DW'(-b_perp_reg) : DW'(b_perp_reg);
    assign ne_c = (64'(pabs) > 64'(radius));

    // stage d: discriminant
    logic [DISC_W-1:0] rr, pp;

    assign rr = radius * radius;
    assign pp = c_pm_reg * c_pm_reg;

    // square root, one result bit per stage
    logic [DISC_W-1:0]    q_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]    q_root_reg [ROOT_W+1];
    logic signed [DW-1:0] q_dot_reg  [ROOT_W+1];
    logic                 q_v_reg    [ROOT_W+1];
    logic                 q_ne_reg   [ROOT_W+1];
    logic                 q_z_reg    [ROOT_W+1];
    logic [SPEED_W-1:0]   q_s_reg    [ROOT_W+1];
    logic [DISC_W-1:0]    q_rem_next  [ROOT_W];
    logic [ROOT_W-1:0]    q_root_next [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [DISC_W:0] trial;
        logic            fits;
        always_comb
        begin
            trial = ((DISC_W+1)'(q_root_reg[k]) << (B + 1)) | ((DISC_W+1)'(1) << (2 * B));
            fits  = ((DISC_W+1)'(q_rem_reg[k]) >= trial);
            q_rem_next[k]  = fits ? DISC_W'((DISC_W+1)'(q_rem_reg[k]) - trial) : q_rem_reg[k];
            q_root_next[k] = fits ? (q_root_reg[k] | (ROOT_W'(1) << B)) : q_root_reg[k];
        end
    end

    // stage e: distance and its magnitude
    logic signed [EW-1:0] distance;
    logic [EW-1:0]        e_mag_reg;
    logic                 e_neg_reg, e_v_reg, e_ne_reg, e_z_reg;
    logic [SPEED_W-1:0]   e_s_reg;

    always_comb
    begin
        if (q_ne_reg[ROOT_W])
        begin
            distance = -EW'(256);
        end
        else
        begin
            distance = EW'(signed'({1'b0, q_root_reg[ROOT_W]})) - EW'(q_dot_reg[ROOT_W]);
        end
    end

    // stage f: scale to minutes
    logic [PRW-1:0]     f_prod_reg;
    logic               f_neg_reg, f_v_reg, f_ne_reg, f_z_reg;
    logic [SPEED_W-1:0] f_s_reg;

    // stage g: split numerator, catch quotients past 32 bits
    logic [63:0] num;

    assign num = 64'(f_prod_reg >> 16);

    // divider, one quotient bit per stage
    logic [SPEED_W-1:0] d_rem_reg [TIME_W+1];
    logic [TIME_W-1:0]  d_lo_reg  [TIME_W+1];
    logic [TIME_W-1:0]  d_q_reg   [TIME_W+1];
    logic [SPEED_W-1:0] d_s_reg   [TIME_W+1];
    logic               d_v_reg   [TIME_W+1];
    logic               d_neg_reg [TIME_W+1];
    logic               d_ne_reg  [TIME_W+1];
    logic               d_z_reg   [TIME_W+1];
    logic               d_ovf_reg [TIME_W+1];
    logic [SPEED_W-1:0] d_rem_next [TIME_W];
    logic               d_bit      [TIME_W];

    for (genvar k = 0; k < TIME_W; k++)
    begin : g_div
        logic [SPEED_W:0] t;
        always_comb
        begin
            t          = {d_rem_reg[k], d_lo_reg[k][TIME_W-1]};
            d_bit[k]   = (t >= {1'b0, d_s_reg[k]});
            d_rem_next[k] = d_bit[k] ? SPEED_W'(t - {1'b0, d_s_reg[k]}) : SPEED_W'(t);
        end
    end

    // stage h: saturation into the result register
    logic [TIME_W-1:0]        qf;
    logic signed [TIME_W-1:0] time_next;
    logic signed [TIME_W-1:0] time_reg;
    logic                     h_v_reg, h_ne_reg, h_z_reg;

    assign qf = d_q_reg[TIME_W];

    always_comb
    begin
        if (d_z_reg[TIME_W])
        begin
            time_next = TIME_MAX;
        end
        else if (d_neg_reg[TIME_W])
        begin
            time_next = (d_ovf_reg[TIME_W] || qf[TIME_W-1]) ? TIME_MIN : -signed'(qf);
        end
        else
        begin
            time_next = (d_ovf_reg[TIME_W] || qf[TIME_W-1]) ? TIME_MAX : signed'(qf);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
            begin
                q_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= TIME_W; k++)
            begin
                d_v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_v_reg    <= s_v_reg[SLAT-1];
            b_v_reg    <= a_v_reg;
            c_v_reg    <= b_v_reg;
            q_v_reg[0] <= c_v_reg;
            for (int k = 1; k <= ROOT_W; k++)
            begin
                q_v_reg[k] <= q_v_reg[k-1];
            end
            e_v_reg    <= q_v_reg[ROOT_W];
            f_v_reg    <= e_v_reg;
            d_v_reg[0] <= f_v_reg;
            for (int k = 1; k <= TIME_W; k++)
            begin
                d_v_reg[k] <= d_v_reg[k-1];
            end
            h_v_reg <= d_v_reg[TIME_W];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc_reg  <= xc_next;
            ys_reg  <= ys_next;
            xs_reg  <= xs_next;
            yc_reg  <= yc_next;
            a_s_reg <= s_s_reg[SLAT-1];
            a_z_reg <= s_z_reg[SLAT-1];

            b_dot_reg  <= DW'(dsum >>> 30);
            b_perp_reg <= DW'(psum >>> 30);
            b_s_reg    <= a_s_reg;
            b_z_reg    <= a_z_reg;

            c_dot_reg <= b_dot_reg;
            c_ne_reg  <= ne_c;
            c_pm_reg  <= ne_c ? '0 : RADIUS_W'(pabs);
            c_s_reg   <= b_s_reg;
            c_z_reg   <= b_z_reg;

            q_rem_reg[0]  <= rr - pp;
            q_root_reg[0] <= '0;
            q_dot_reg[0]  <= c_dot_reg;
            q_ne_reg[0]   <= c_ne_reg;
            q_s_reg[0]    <= c_s_reg;
            q_z_reg[0]    <= c_z_reg;
            for (int k = 0; k < ROOT_W; k++)
            begin
                q_rem_reg[k+1]  <= q_rem_next[k];
                q_root_reg[k+1] <= q_root_next[k];
                q_dot_reg[k+1]  <= q_dot_reg[k];
                q_ne_reg[k+1]   <= q_ne_reg[k];
                q_s_reg[k+1]    <= q_s_reg[k];
                q_z_reg[k+1]    <= q_z_reg[k];
            end

            e_neg_reg <= (distance < 0);
            e_mag_reg <= (distance < 0) ? EW'(-distance) : EW'(distance);
            e_ne_reg  <= q_ne_reg[ROOT_W];
            e_s_reg   <= q_s_reg[ROOT_W];
            e_z_reg   <= q_z_reg[ROOT_W];

            f_prod_reg <= e_mag_reg * MIN_PER_NM_Q16;
            f_neg_reg  <= e_neg_reg;
            f_ne_reg   <= e_ne_reg;
            f_s_reg    <= e_s_reg;
            f_z_reg    <= e_z_reg;

            d_rem_reg[0] <= num[TIME_W +: SPEED_W];
            d_lo_reg[0]  <= num[TIME_W-1:0];
            d_q_reg[0]   <= '0;
            d_ovf_reg[0] <= (num[63:TIME_W] >= TIME_W'(f_s_reg));
            d_s_reg[0]   <= f_s_reg;
            d_neg_reg[0] <= f_neg_reg;
            d_ne_reg[0]  <= f_ne_reg;
            d_z_reg[0]   <= f_z_reg;
            for (int k = 0; k < TIME_W; k++)
            begin
                d_rem_reg[k+1] <= d_rem_next[k];
                d_lo_reg[k+1]  <= d_lo_reg[k] << 1;
                d_q_reg[k+1]   <= {d_q_reg[k][TIME_W-2:0], d_bit[k]};
                d_ovf_reg[k+1] <= d_ovf_reg[k];
                d_s_reg[k+1]   <= d_s_reg[k];
                d_neg_reg[k+1] <= d_neg_reg[k];
                d_ne_reg[k+1]  <= d_ne_reg[k];
                d_z_reg[k+1]   <= d_z_reg[k];
            end

            time_reg <= time_next;
            h_ne_reg <= d_ne_reg[TIME_W];
            h_z_reg  <= d_z_reg[TIME_W];
        end
    end

    assign out_valid    = h_v_reg;
    assign exit_minutes = time_reg;
    assign no_exit      = h_ne_reg;
    assign zero_speed   = h_z_reg;

endmodule

// File: rtl/core/circle_exit_time_core.sv
// circle_exit_time_core: time to leave a circle about the origin along a heading
// a push passes queue, sine lanes, stages a to c, square root, e, f, divider and h
// throughput one transaction per cycle; an unpopped result stalls the back pipeline
// a two-entry queue lets the front keep taking transactions during a short stall
// reset (rst_n low, asynchronous) empties all queues and sets the radius to 1000.0
// depends on cet_pkg, cet_front, cet_queue, cet_sine, cet_back

module circle_exit_time_core
    import cet_pkg::*;
#(
    parameter int POS_WIDTH   = POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input queue side
    input  logic                        push,
    output logic                        full,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic [ANGLE_WIDTH-1:0]      heading,
    input  logic [SPEED_W-1:0]          speed_knots,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output logic signed [TIME_W-1:0]    exit_minutes,
    output logic                        no_exit,
    output logic                        zero_speed,
    // radius write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [RADIUS_W-1:0]         cfg_data
);

    localparam int QW = 2 * POS_WIDTH + $bits(cls_t);

    logic [RADIUS_W-1:0] radius_reg;

    // radius register, written whenever the channel offers data
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    // front: classify the heading into quadrant and quarter-turn offsets
    cls_t cls_in;

    cet_front #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .heading     (heading),
        .speed_knots (speed_knots),
        .cls         (cls_in)
    );

    // queue between front and back
    logic [QW-1:0]               q_rdata;
    logic                        q_empty;
    logic                        q_pop;
    logic                        adv;
    logic                        res_valid;
    logic signed [POS_WIDTH-1:0] q_x, q_y;
    cls_t                        q_cls;

    cet_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({pos_x, pos_y, cls_in}),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {q_x, q_y, q_cls} = q_rdata;

    // the whole back pipeline moves unless a result waits unpopped
    assign adv   = !res_valid || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !res_valid;

    cet_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (!q_empty),
        .in_x         (q_x),
        .in_y         (q_y),
        .in_cls       (q_cls),
        .radius       (radius_reg),
        .out_valid    (res_valid),
        .exit_minutes (exit_minutes),
        .no_exit      (no_exit),
        .zero_speed   (zero_speed)
    );

    // zero speed always shows the saturated maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && zero_speed) |-> (exit_minutes == TIME_MAX))
        else $error("zero speed result not saturated");

    // no crossing means a negative distance, so never a positive time
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && no_exit && !zero_speed) |-> (exit_minutes <= 0))
        else $error("no exit result with positive time");

    // a waiting result that is not taken stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(exit_minutes) && $stable(no_exit)))
        else $error("waiting result changed");

    // the back only draws from the queue when it holds something
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty internal queue");

endmodule
